// ----- rtl/ps2_set1_scancode_to_ascii_fifo_unit_defines.svh -----
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: assertion macros
// Clocked assertion helpers used by the scancode ring, the RTL file that checks itself.
// -----------------------------------------------------------------------------
`ifndef PS2_SET1_SCANCODE_TO_ASCII_FIFO_UNIT_DEFINES_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_FIFO_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define PS2S1_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define PS2S1_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/ps2s1_pkg.sv -----
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: package
// Item types, status codes, scancode constants and the set-1 key tables.
// -----------------------------------------------------------------------------
`default_nettype none

package ps2s1_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 32;

   // Opcodes of an input item
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_DROPPED = 3'd1;
   localparam logic [2:0] ST_CHAR    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_NOCHAR  = 3'd4;

   // Scancodes with special meaning
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

   typedef struct packed {
      logic       opcode;
      logic [7:0] scan_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] character;
   } rsp_type;

   // What the ring did with an item
   typedef enum logic [1:0] {
      KIND_STORED,
      KIND_DROPPED,
      KIND_EMPTY,
      KIND_POPPED
   } kind_type;

   // Item handed from the ring stage to the decode stage
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] code;
   } stage_type;

   function automatic logic [6:0] plain_char(input logic [6:0] code);
      logic [6:0] ch;
      case (code)
         7'd1:    ch = 7'h1B;
         7'd2:    ch = 7'h31;
         7'd3:    ch = 7'h32;
         7'd4:    ch = 7'h33;
         7'd5:    ch = 7'h34;
         7'd6:    ch = 7'h35;
         7'd7:    ch = 7'h36;
         7'd8:    ch = 7'h37;
         7'd9:    ch = 7'h38;
         7'd10:   ch = 7'h39;
         7'd11:   ch = 7'h30;
         7'd12:   ch = 7'h2D;
         7'd13:   ch = 7'h3D;
         7'd14:   ch = 7'h08;
         7'd15:   ch = 7'h09;
         7'd16:   ch = 7'h71;
         7'd17:   ch = 7'h77;
         7'd18:   ch = 7'h65;
         7'd19:   ch = 7'h72;
         7'd20:   ch = 7'h74;
         7'd21:   ch = 7'h79;
         7'd22:   ch = 7'h75;
         7'd23:   ch = 7'h69;
         7'd24:   ch = 7'h6F;
         7'd25:   ch = 7'h70;
         7'd26:   ch = 7'h5B;
         7'd27:   ch = 7'h5D;
         7'd28:   ch = 7'h0A;
         7'd30:   ch = 7'h61;
         7'd31:   ch = 7'h73;
         7'd32:   ch = 7'h64;
         7'd33:   ch = 7'h66;
         7'd34:   ch = 7'h67;
         7'd35:   ch = 7'h68;
         7'd36:   ch = 7'h6A;
         7'd37:   ch = 7'h6B;
         7'd38:   ch = 7'h6C;
         7'd39:   ch = 7'h3B;
         7'd40:   ch = 7'h27;
         7'd41:   ch = 7'h60;
         7'd44:   ch = 7'h7A;
         7'd45:   ch = 7'h78;
         7'd46:   ch = 7'h63;
         7'd47:   ch = 7'h76;
         7'd48:   ch = 7'h62;
         7'd49:   ch = 7'h6E;
         7'd50:   ch = 7'h6D;
         7'd51:   ch = 7'h2C;
         7'd52:   ch = 7'h2E;
         7'd53:   ch = 7'h2F;
         7'd57:   ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] shifted_char(input logic [6:0] code);
      logic [6:0] ch;
      case (code)
         7'd2:    ch = 7'h21;
         7'd3:    ch = 7'h40;
         7'd4:    ch = 7'h23;
         7'd5:    ch = 7'h24;
         7'd6:    ch = 7'h25;
         7'd7:    ch = 7'h5E;
         7'd8:    ch = 7'h26;
         7'd9:    ch = 7'h2A;
         7'd10:   ch = 7'h28;
         7'd11:   ch = 7'h29;
         7'd12:   ch = 7'h5F;
         7'd13:   ch = 7'h2B;
         7'd16:   ch = 7'h51;
         7'd17:   ch = 7'h57;
         7'd18:   ch = 7'h45;
         7'd19:   ch = 7'h52;
         7'd20:   ch = 7'h54;
         7'd21:   ch = 7'h59;
         7'd22:   ch = 7'h55;
         7'd23:   ch = 7'h49;
         7'd24:   ch = 7'h4F;
         7'd25:   ch = 7'h50;
         7'd26:   ch = 7'h7B;
         7'd27:   ch = 7'h7D;
         7'd30:   ch = 7'h41;
         7'd31:   ch = 7'h53;
         7'd32:   ch = 7'h44;
         7'd33:   ch = 7'h46;
         7'd34:   ch = 7'h47;
         7'd35:   ch = 7'h48;
         7'd36:   ch = 7'h4A;
         7'd37:   ch = 7'h4B;
         7'd38:   ch = 7'h4C;
         7'd39:   ch = 7'h3A;
         7'd40:   ch = 7'h22;
         7'd41:   ch = 7'h7E;
         7'd44:   ch = 7'h5A;
         7'd45:   ch = 7'h58;
         7'd46:   ch = 7'h43;
         7'd47:   ch = 7'h56;
         7'd48:   ch = 7'h42;
         7'd49:   ch = 7'h4E;
         7'd50:   ch = 7'h4D;
         7'd51:   ch = 7'h3C;
         7'd52:   ch = 7'h3E;
         7'd53:   ch = 7'h3F;
         7'd57:   ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ps2s1_ring.sv -----
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: scancode ring
// Takes input items, pushes scancodes into the ring memory or pops the oldest
// one, and registers the outcome for the decode stage.
// -----------------------------------------------------------------------------
`default_nettype none
`include "ps2_set1_scancode_to_ascii_fifo_unit_defines.svh"

module ps2s1_ring #(
   parameter int BUFFER_DEPTH = ps2s1_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ps2s1_pkg::req_type  req_data,
   input  wire                 stage_advance,
   output ps2s1_pkg::stage_type stage
);

   localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

   logic [7:0]       mem [BUFFER_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_next, rp_next;
   logic             stage_valid_ff, stage_valid_in;
   ps2s1_pkg::kind_type kind_ff, kind_in;
   logic [7:0]       code_ff;
   logic             accept, full, empty, do_push, do_pop;

   assign wp_next = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_next = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
   assign full    = (wp_next == rp_ff);
   assign empty   = (wp_ff == rp_ff);

   assign req_stall = stage_valid_ff && !stage_advance;
   assign accept    = req_valid && !req_stall;
   assign do_push   = accept && (req_data.opcode == ps2s1_pkg::OP_SCAN) && !full;
   assign do_pop    = accept && (req_data.opcode == ps2s1_pkg::OP_READ) && !empty;

   always_comb begin
      wp_in = do_push ? wp_next : wp_ff;
      rp_in = do_pop  ? rp_next : rp_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
      if (req_data.opcode == ps2s1_pkg::OP_SCAN) begin
         kind_in = full ? ps2s1_pkg::KIND_DROPPED : ps2s1_pkg::KIND_STORED;
      end else begin
         kind_in = empty ? ps2s1_pkg::KIND_EMPTY : ps2s1_pkg::KIND_POPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         rp_ff          <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         wp_ff          <= wp_in;
         rp_ff          <= rp_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Hold kind while the stage is stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= req_data.scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         code_ff <= mem[rp_ff];
      end
   end

   assign stage.valid = stage_valid_ff;
   assign stage.kind  = kind_ff;
   assign stage.code  = code_ff;

   `PS2S1_ASSERT(a_wp_range, wp_ff <= PTR_LAST, "write pointer out of range")
   `PS2S1_ASSERT(a_rp_range, rp_ff <= PTR_LAST, "read pointer out of range")
   `PS2S1_ASSERT(a_full_holds, (accept && full && req_data.opcode == ps2s1_pkg::OP_SCAN) |=> (wp_ff == $past(wp_ff)), "push into full ring moved write pointer")
   `PS2S1_ASSERT(a_empty_holds, (accept && empty && req_data.opcode == ps2s1_pkg::OP_READ) |=> (rp_ff == $past(rp_ff)), "pop from empty ring moved read pointer")

endmodule

`default_nettype wire

// ----- rtl/ps2s1_decode.sv -----
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: decoder
// Tracks shift and caps lock, maps popped make codes to ASCII and holds the
// result item in the output register.
// -----------------------------------------------------------------------------
`default_nettype none

module ps2s1_decode (
   input  wire                  clock,
   input  wire                  reset,
   input  ps2s1_pkg::stage_type stage,
   output logic                 stage_advance,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output ps2s1_pkg::rsp_type   rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   ps2s1_pkg::rsp_type rsp_ff, rsp_in;
   logic               shift_ff, shift_in;
   logic               caps_ff, caps_in;
   logic               load;
   logic [6:0]         ch;

   assign stage_advance = !rsp_valid_ff || !rsp_stall;
   assign load          = stage.valid && stage_advance;

   always_comb begin
      ch = shift_ff ? ps2s1_pkg::shifted_char(stage.code[6:0])
                    : ps2s1_pkg::plain_char(stage.code[6:0]);
      // Caps flips letters only
      if (caps_ff && ((ch inside {[7'h61:7'h7A]}) || (ch inside {[7'h41:7'h5A]}))) begin
         ch = ch ^ 7'h20;
      end
   end

   always_comb begin
      shift_in         = shift_ff;
      caps_in          = caps_ff;
      rsp_in.status    = ps2s1_pkg::ST_NOCHAR;
      rsp_in.character = 7'h00;
      case (stage.kind)
         ps2s1_pkg::KIND_STORED:  rsp_in.status = ps2s1_pkg::ST_STORED;
         ps2s1_pkg::KIND_DROPPED: rsp_in.status = ps2s1_pkg::ST_DROPPED;
         ps2s1_pkg::KIND_EMPTY:   rsp_in.status = ps2s1_pkg::ST_EMPTY;
         ps2s1_pkg::KIND_POPPED: begin
            if (stage.code inside {ps2s1_pkg::SC_LSHIFT_MAKE, ps2s1_pkg::SC_RSHIFT_MAKE}) begin
               shift_in = 1'b1;
            end else if (stage.code inside {ps2s1_pkg::SC_LSHIFT_BREAK,
                                            ps2s1_pkg::SC_RSHIFT_BREAK}) begin
               shift_in = 1'b0;
            end else if (stage.code == ps2s1_pkg::SC_CAPS_MAKE) begin
               caps_in = !caps_ff;
            end else if (!stage.code[7] && (ch != 7'h00)) begin
               rsp_in.status    = ps2s1_pkg::ST_CHAR;
               rsp_in.character = ch;
            end
         end
         default: rsp_in.status = ps2s1_pkg::ST_NOCHAR;
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            shift_ff <= shift_in;
            caps_ff  <= caps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/ps2_set1_scancode_to_ascii_fifo_unit.sv -----
// Path: an accepted input item is registered in the ring stage, then its result item
// is registered in the result register, where it becomes valid.
// Throughput: one item per cycle while no stall holds the stages, set by the ring
// and decode stages, one item each; ring memory has one write and one read port.
// Reset clears the ring pointers, shift and caps flags and both valid bits;
// the ring memory itself is not cleared.
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: top level
// Buffers raw set-1 scancodes in a ring and decodes them to ASCII on request.
// -----------------------------------------------------------------------------
`default_nettype none

module ps2_set1_scancode_to_ascii_fifo_unit #(
   parameter int BUFFER_DEPTH = ps2s1_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  ps2s1_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output ps2s1_pkg::rsp_type rsp_data
);

   ps2s1_pkg::stage_type stage;
   logic                 stage_advance;

   ps2s1_ring #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_ring (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .stage_advance (stage_advance),
      .stage         (stage)
   );

   ps2s1_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .stage_advance (stage_advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/ps2_set1_scancode_to_ascii_fifo_unit_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// PS/2 set-1 keyboard unit: regression bench
// Drives scancode and read items through the valid/stall request channel,
// predicts results from the script or an independent model of ring and set-1
// decoder, and checks each result in order under several traffic patterns.
// -----------------------------------------------------------------------------

module ps2_set1_scancode_to_ascii_fifo_unit_tb;

   import ps2s1_pkg::*;

   localparam int DEPTH        = BUFFER_DEPTH_DEFAULT;
   localparam int N_DIRECTED   = 24;
   localparam int PHASE_ITEMS  = 80;
   localparam int BACKLOG_HOLD = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [9:0] PREDICTED = 10'h000;

   typedef enum {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_BOTH_GAPS,
      PH_BACKLOG
   } traffic_phase_type;

   // One row of the directed script: an item and, where typed, its result
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type rsp;
   } script_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic    row_typed = 1'b0;
   rsp_type row_rsp   = '0;

   traffic_phase_type phase = PH_STEADY;
   int                failures = 0;
   rsp_type           awaited_results[$];

   // Independent copy of the keyboard state
   logic [7:0] scan_ring [DEPTH];
   int         wr_ptr     = 0;
   int         rd_ptr     = 0;
   logic       shift_on   = 1'b0;
   logic       caps_model = 1'b0;
   logic [6:0] plain_keys [128];
   logic [6:0] shift_keys [128];

   script_row_type directed_rows [N_DIRECTED] = '{
      {OP_READ, 8'hFF, 1'b1, ST_EMPTY,   7'h00},
      {OP_SCAN, 8'h00, 1'b1, ST_STORED,  7'h00},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_SCAN, 8'h7F, 1'b1, ST_STORED,  7'h00},
      {OP_SCAN, 8'hFF, 1'b1, ST_STORED,  7'h00},
      {OP_READ, 8'h55, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'hAA, 1'b1, ST_NOCHAR,  7'h00},
      {OP_SCAN, SC_LSHIFT_MAKE,  1'b1, ST_STORED, 7'h00},
      {OP_SCAN, 8'h1E, 1'b1, ST_STORED,  7'h00},
      {OP_SCAN, SC_RSHIFT_MAKE,  1'b1, ST_STORED, 7'h00},
      {OP_SCAN, SC_CAPS_MAKE,    1'b1, ST_STORED, 7'h00},
      {OP_SCAN, 8'h02, 1'b1, ST_STORED,  7'h00},
      {OP_SCAN, SC_RSHIFT_BREAK, 1'b1, ST_STORED, 7'h00},
      {OP_SCAN, 8'h1E, 1'b1, ST_STORED,  7'h00},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'h00, 1'b0, PREDICTED},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'h00, 1'b0, PREDICTED},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'h00, 1'b0, PREDICTED},
      {OP_SCAN, SC_LSHIFT_BREAK, 1'b1, ST_STORED, 7'h00},
      {OP_READ, 8'h00, 1'b1, ST_NOCHAR,  7'h00},
      {OP_READ, 8'hFF, 1'b1, ST_EMPTY,   7'h00}
   };

   ps2_set1_scancode_to_ascii_fifo_unit #(
      .BUFFER_DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("ps2_set1_scancode_to_ascii_fifo_unit regression: fail");
      $finish;
   end

   // Place a run of characters at consecutive scancodes
   task automatic lay_keys(input logic shifted, input int first, input string keys);
      for (int i = 0; i < keys.len(); i++) begin
         if (shifted)
            shift_keys[first + i] = 7'(keys[i]);
         else
            plain_keys[first + i] = 7'(keys[i]);
      end
   endtask

   function automatic rsp_type predict_keyboard(input req_type item);
      rsp_type    r;
      logic [7:0] code;
      logic [6:0] ch;
      r = '0;
      if (item.opcode == OP_SCAN) begin
         if ((wr_ptr + 1) % DEPTH != rd_ptr) begin
            scan_ring[wr_ptr] = item.scan_byte;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            r.status = ST_STORED;
         end else begin
            r.status = ST_DROPPED;
         end
      end else if (rd_ptr == wr_ptr) begin
         r.status = ST_EMPTY;
      end else begin
         code = scan_ring[rd_ptr];
         rd_ptr = (rd_ptr + 1) % DEPTH;
         r.status = ST_NOCHAR;
         if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
            shift_on = 1'b1;
         end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
            shift_on = 1'b0;
         end else if (code == SC_CAPS_MAKE) begin
            caps_model = ~caps_model;
         end else if (!code[7]) begin
            ch = shift_on ? shift_keys[code[6:0]] : plain_keys[code[6:0]];
            // caps flips the case of letters only
            if (caps_model && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A)))
               ch = ch ^ 7'h20;
            if (ch != 7'h00) begin
               r.status = ST_CHAR;
               r.character = ch;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, status %0d character %h",
                        $time, rsp_data.status, rsp_data.character);
               failures++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.character !== want.character) begin
                  $display("%0t: character mismatch, expected %h actual %h",
                           $time, want.character, rsp_data.character);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_keyboard(req_data);
            if (row_typed)
               want = row_rsp;
            awaited_results.push_back(want);
         end
      end
   end

   initial begin : receiver
      int held;
      int stall_pct;
      held = 0;
      forever begin
         @(posedge clock);
         case (phase)
            PH_RECV_STALLS: stall_pct = 73;
            PH_BOTH_GAPS:   stall_pct = 7;
            default:        stall_pct = 0;
         endcase
         // hold off long enough for the block to back up into its input
         if (phase == PH_BACKLOG && held < BACKLOG_HOLD) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic offer(input req_type item, input logic typed, input rsp_type rsp);
      int idle_pct;
      case (phase)
         PH_SEND_GAPS: idle_pct = 73;
         PH_BOTH_GAPS: idle_pct = 7;
         default:      idle_pct = 0;
      endcase
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      row_typed <= typed;
      row_rsp   <= rsp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Typing bursts: scancodes then up to burst+3 reads, or a burst of random items
   task automatic play_random(input int n);
      int      sent;
      int      burst;
      int      reads;
      req_type item;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 36);
         if ($urandom_range(0, 4) == 0) begin
            repeat (burst) begin
               item.opcode    = 1'($urandom_range(0, 1));
               item.scan_byte = 8'($urandom_range(0, 255));
               offer(item, 1'b0, '0);
            end
            sent += burst;
         end else begin
            repeat (burst) begin
               item.opcode = OP_SCAN;
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: item.scan_byte = 8'($urandom_range(1, 57));
                  4: begin
                     case ($urandom_range(0, 4))
                        0:       item.scan_byte = SC_LSHIFT_MAKE;
                        1:       item.scan_byte = SC_RSHIFT_MAKE;
                        2:       item.scan_byte = SC_LSHIFT_BREAK;
                        3:       item.scan_byte = SC_RSHIFT_BREAK;
                        default: item.scan_byte = SC_CAPS_MAKE;
                     endcase
                  end
                  5, 6:    item.scan_byte = {1'b1, 7'($urandom_range(1, 57))};
                  default: item.scan_byte = 8'($urandom_range(0, 255));
               endcase
               offer(item, 1'b0, '0);
            end
            reads = $urandom_range(1, burst + 3);
            repeat (reads) begin
               item.opcode    = OP_READ;
               item.scan_byte = 8'($urandom_range(0, 255));
               offer(item, 1'b0, '0);
            end
            sent += burst + reads;
         end
      end
   endtask

   initial begin : stimulus
      traffic_phase_type order [5];
      order = '{PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH_GAPS, PH_BACKLOG};
      for (int i = 0; i < 128; i++) begin
         plain_keys[i] = 7'h00;
         shift_keys[i] = 7'h00;
      end
      lay_keys(1'b0, 2, "1234567890-=");
      lay_keys(1'b0, 16, "qwertyuiop[]");
      lay_keys(1'b0, 30, "asdfghjkl;'");
      lay_keys(1'b0, 44, "zxcvbnm,./");
      lay_keys(1'b1, 2, "!@#$%^&*()_+");
      lay_keys(1'b1, 16, "QWERTYUIOP{}");
      lay_keys(1'b1, 30, "ASDFGHJKL:\"~");
      lay_keys(1'b1, 44, "ZXCVBNM<>?");
      plain_keys[1]  = 7'h1B;
      plain_keys[14] = 7'h08;
      plain_keys[15] = 7'h09;
      plain_keys[28] = 7'h0A;
      plain_keys[41] = 7'h60;
      plain_keys[57] = 7'h20;
      shift_keys[57] = 7'h20;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++)
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].rsp);

      foreach (order[p]) begin
         req_valid <= 1'b0;
         // let the last accepted item reach the queue, then wait until it drains
         @(posedge clock);
         while (awaited_results.size() != 0)
            @(posedge clock);
         phase = order[p];
         play_random(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("ps2_set1_scancode_to_ascii_fifo_unit regression: pass");
      else
         $display("ps2_set1_scancode_to_ascii_fifo_unit regression: fail");
      $finish;
   end

endmodule
